@@ hdl/zrp_pkg.sv @@
// Shared constants, command and store-port types for the zero-run packer.
// No dependencies; every other file but zrp_checker imports this package.
`timescale 1ns / 1ps
`default_nettype none

package zrp_pkg;

    // Literal bytes one block may hold before it is split.
    localparam int LIT_MAX   = 32;
    // Width of the leading zero counter.
    localparam int ZC_W      = 32;
    localparam int LC_W      = $clog2(LIT_MAX + 1);
    localparam int IDX_W     = $clog2(LIT_MAX);
    // Pending zeros inside a block stay below the threshold.
    localparam int TZ_W      = 5;
    localparam int CFG_W     = 5;
    localparam int SUM_W     = $clog2(LIT_MAX + (2 ** TZ_W) + 1);
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int VARINT_BITS = 7;

    localparam logic [CFG_W-1:0] RUN_THR_RST = CFG_W'(4);
    localparam logic [ZC_W-1:0]  ZC_MAX      = {ZC_W{1'b1}};

    // One pair to emit: varint(zc), varint(lc), then lc bytes of a bank.
    typedef struct packed {
        logic [ZC_W-1:0] zc;
        logic [LC_W-1:0] lc;
        logic            bank;
        logic            last_run;
        logic            eos;
    } zrp_cmd_t;

    // Literal store write from the front.
    typedef struct packed {
        logic             we;
        logic             clr;
        logic             bank;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } zrp_wr_t;

    // Back has finished reading a bank.
    typedef struct packed {
        logic valid;
        logic bank;
    } zrp_done_t;

endpackage

`default_nettype wire

@@ hdl/zrp_front.sv @@
// Front of the zero-run packer: takes raw bytes, tracks zero runs and blocks,
// writes literals and issues pair commands. Depends on zrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zrp_front (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,
    input  wire logic                   s_tlast,
    input  wire logic                   cfg_we,
    input  wire logic [zrp_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                   q_full,
    output logic                        q_push,
    output zrp_pkg::zrp_cmd_t           q_cmd,
    output zrp_pkg::zrp_wr_t            wr,
    input  wire zrp_pkg::zrp_done_t     done
);
    import zrp_pkg::*;

    logic             in_lit_reg, in_lit_next;
    logic [ZC_W-1:0]  lead_reg, lead_next;
    logic [LC_W-1:0]  lc_reg, lc_next;
    logic [TZ_W-1:0]  tz_reg, tz_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic             pend_valid_reg, pend_valid_next;
    zrp_cmd_t         pend_cmd_reg, pend_cmd_next;
    logic [CFG_W-1:0] min_run_reg;

    logic             accept;
    logic             byte_zero;
    logic [TZ_W-1:0]  thr;
    logic [TZ_W-1:0]  tz_inc;
    logic [ZC_W-1:0]  lead_inc;
    logic [SUM_W-1:0] fill;
    logic [SUM_W-1:0] fill_s;
    logic             near_full;
    logic [ZC_W-1:0]  lead_e;
    logic             a_v, b_v, c_v;
    zrp_cmd_t         cmd_a, cmd_b, cmd_c;
    zrp_cmd_t         first_cmd, second_cmd;
    logic             first_v, second_v;
    logic [1:0]       busy_set;
    logic [1:0]       busy_clr;

    assign thr       = (min_run_reg == '0) ? TZ_W'(1) : TZ_W'(min_run_reg);
    assign byte_zero = (s_tdata == 8'h00);
    assign tz_inc    = tz_reg + TZ_W'(1);
    assign lead_inc  = lead_reg + ZC_W'(1);
    assign fill      = SUM_W'(lc_reg) + SUM_W'(tz_reg);
    assign near_full = (fill + SUM_W'(1)) > SUM_W'(LIT_MAX);

    // The current bank must be free; a nearly full block may also spill
    // into the other bank.
    assign s_tready = !q_full && !pend_valid_reg && !busy_reg[bank_reg]
                      && !(in_lit_reg && near_full && busy_reg[~bank_reg]);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_lit_next = in_lit_reg;
        lead_next   = lead_reg;
        lc_next     = lc_reg;
        tz_next     = tz_reg;
        bank_next   = bank_reg;
        a_v         = 1'b0;
        b_v         = 1'b0;
        c_v         = 1'b0;
        cmd_a       = '0;
        cmd_b       = '0;
        cmd_c       = '0;
        busy_set    = '0;
        wr          = '0;
        fill_s      = '0;
        lead_e      = '0;

        if (accept) begin
            if (!in_lit_reg) begin
                if (byte_zero) begin
                    lead_next = lead_inc;
                    if (lead_inc == ZC_MAX) begin
                        a_v       = 1'b1;
                        cmd_a.zc  = lead_inc;
                        lead_next = '0;
                    end
                end else begin
                    in_lit_next = 1'b1;
                    lc_next     = LC_W'(1);
                    tz_next     = '0;
                    wr.we       = 1'b1;
                    wr.clr      = 1'b1;
                    wr.bank     = bank_reg;
                    wr.idx      = '0;
                    wr.data     = s_tdata;
                end
            end else if (byte_zero) begin
                if (tz_inc >= thr) begin
                    // Run reached the threshold: close the block.
                    a_v                = 1'b1;
                    cmd_a.zc           = lead_reg;
                    cmd_a.lc           = lc_reg;
                    cmd_a.bank         = bank_reg;
                    busy_set[bank_reg] = 1'b1;
                    bank_next          = ~bank_reg;
                    in_lit_next        = 1'b0;
                    lead_next          = ZC_W'(tz_inc);
                    tz_next            = '0;
                    lc_next            = '0;
                end else begin
                    tz_next = tz_inc;
                end
            end else if (near_full) begin
                // Block full: emit it, open a new one in the other bank.
                a_v                = 1'b1;
                cmd_a.zc           = lead_reg;
                cmd_a.lc           = lc_reg;
                cmd_a.bank         = bank_reg;
                busy_set[bank_reg] = 1'b1;
                bank_next          = ~bank_reg;
                lead_next          = ZC_W'(tz_reg);
                tz_next            = '0;
                lc_next            = LC_W'(1);
                wr.we              = 1'b1;
                wr.clr             = 1'b1;
                wr.bank            = ~bank_reg;
                wr.idx             = '0;
                wr.data            = s_tdata;
            end else begin
                // Pending zeros join the block; their entries keep a clear
                // nonzero mark, so only the byte itself is written.
                lc_next = LC_W'(fill + SUM_W'(1));
                tz_next = '0;
                wr.we   = 1'b1;
                wr.bank = bank_reg;
                wr.idx  = IDX_W'(fill);
                wr.data = s_tdata;
            end

            if (s_tlast) begin
                fill_s = SUM_W'(lc_next) + SUM_W'(tz_next);
                lead_e = lead_next;
                if (in_lit_next) begin
                    b_v                 = 1'b1;
                    cmd_b.zc            = lead_next;
                    cmd_b.bank          = bank_next;
                    busy_set[bank_next] = 1'b1;
                    if (fill_s > SUM_W'(LIT_MAX)) begin
                        cmd_b.lc = lc_next;
                        lead_e   = ZC_W'(tz_next);
                    end else begin
                        cmd_b.lc = LC_W'(fill_s);
                        lead_e   = '0;
                    end
                    bank_next = ~bank_next;
                end
                if (lead_e != '0) begin
                    c_v      = 1'b1;
                    cmd_c.zc = lead_e;
                end
                in_lit_next = 1'b0;
                lead_next   = '0;
                lc_next     = '0;
                tz_next     = '0;
            end
        end
    end

    // At most two pairs per item; the second waits in pend until the queue has room.
    always_comb begin
        first_v    = a_v || b_v || c_v;
        second_v   = (a_v && (b_v || c_v)) || (b_v && c_v);
        first_cmd  = a_v ? cmd_a : (b_v ? cmd_b : cmd_c);
        second_cmd = (a_v && b_v) ? cmd_b : cmd_c;
        if (second_v) begin
            second_cmd.last_run = 1'b1;
            second_cmd.eos      = s_tlast;
        end else begin
            first_cmd.last_run = 1'b1;
            first_cmd.eos      = s_tlast;
        end

        q_push = pend_valid_reg ? !q_full : (accept && first_v);
        q_cmd  = pend_valid_reg ? pend_cmd_reg : first_cmd;

        pend_valid_next = pend_valid_reg;
        pend_cmd_next   = pend_cmd_reg;
        if (pend_valid_reg && !q_full) begin
            pend_valid_next = 1'b0;
        end
        if (accept && second_v) begin
            pend_valid_next = 1'b1;
            pend_cmd_next   = second_cmd;
        end

        busy_clr = '0;
        if (done.valid) begin
            busy_clr[done.bank] = 1'b1;
        end
        busy_next = (busy_reg & ~busy_clr) | busy_set;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_lit_reg     <= 1'b0;
            lead_reg       <= '0;
            lc_reg         <= '0;
            tz_reg         <= '0;
            bank_reg       <= 1'b0;
            busy_reg       <= '0;
            pend_valid_reg <= 1'b0;
            min_run_reg    <= RUN_THR_RST;
        end else begin
            in_lit_reg     <= in_lit_next;
            lead_reg       <= lead_next;
            lc_reg         <= lc_next;
            tz_reg         <= tz_next;
            bank_reg       <= bank_next;
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we) begin
                min_run_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_cmd_reg <= pend_cmd_next;
    end

endmodule

`default_nettype wire

@@ hdl/zrp_queue.sv @@
// Short command queue between the front and back of the zero-run packer.
// Depends on zrp_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module zrp_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire zrp_pkg::zrp_cmd_t push_cmd,
    output logic                   full,
    input  wire logic              pop,
    output logic                   valid,
    output zrp_pkg::zrp_cmd_t      head
);
    import zrp_pkg::*;

    zrp_cmd_t             slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wp_reg, wp_next;
    logic [Q_PTR_W-1:0]   rp_reg, rp_next;
    logic [Q_PTR_W:0]     cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign full    = (cnt_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = slot_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wp_next = (wp_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp_reg + Q_PTR_W'(1);
        end
        if (do_pop) begin
            rp_next = (rp_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp_reg + Q_PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + (Q_PTR_W + 1)'(1);
            2'b01:   cnt_next = cnt_reg - (Q_PTR_W + 1)'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wp_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hdl/zrp_back.sv @@
// Back of the zero-run packer: holds the two-bank literal store and turns
// each pair command into varint and literal bytes. Depends on zrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zrp_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire zrp_pkg::zrp_cmd_t q_cmd,
    input  wire zrp_pkg::zrp_wr_t  wr,
    output zrp_pkg::zrp_done_t     done,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);
    import zrp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ZC,
        ST_LC,
        ST_LIT
    } state_t;

    state_t           state_reg, state_next;
    logic [ZC_W-1:0]  val_reg, val_next;
    logic [LC_W-1:0]  lc_reg, lc_next;
    logic             bank_reg, bank_next;
    logic             last_run_reg, last_run_next;
    logic             eos_reg, eos_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;
    logic             m_eos_reg, m_eos_next;

    logic [7:0]         lit_mem [2][LIT_MAX];
    logic [LIT_MAX-1:0] nz_reg [2];
    logic [LIT_MAX-1:0] nz_wr;
    logic [7:0]         rd_byte_reg;
    logic               rd_nz_reg;

    logic       out_ready;
    logic       more;
    logic [7:0] vbyte;
    logic       idx_last;

    assign out_ready = !m_valid_reg || m_tready;
    assign more      = |val_reg[ZC_W-1:VARINT_BITS];
    assign vbyte     = {more, val_reg[VARINT_BITS-1:0]};
    assign idx_last  = (LC_W'(idx_reg) + LC_W'(1)) == lc_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_eos_reg;

    always_comb begin
        state_next    = state_reg;
        val_next      = val_reg;
        lc_next       = lc_reg;
        bank_next     = bank_reg;
        last_run_next = last_run_reg;
        eos_next      = eos_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_eos_next    = m_eos_reg;
        q_pop         = 1'b0;
        done          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop         = 1'b1;
                    val_next      = q_cmd.zc;
                    lc_next       = q_cmd.lc;
                    bank_next     = q_cmd.bank;
                    last_run_next = q_cmd.last_run;
                    eos_next      = q_cmd.eos;
                    idx_next      = '0;
                    state_next    = ST_ZC;
                end
            end
            ST_ZC: begin
                if (out_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = vbyte;
                    m_last_next  = 1'b0;
                    m_eos_next   = 1'b0;
                    if (more) begin
                        val_next = val_reg >> VARINT_BITS;
                    end else begin
                        val_next   = ZC_W'(lc_reg);
                        state_next = ST_LC;
                    end
                end
            end
            ST_LC: begin
                if (out_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = vbyte;
                    m_last_next  = 1'b0;
                    m_eos_next   = 1'b0;
                    if (more) begin
                        val_next = val_reg >> VARINT_BITS;
                    end else if (lc_reg == '0) begin
                        m_last_next = last_run_reg;
                        m_eos_next  = eos_reg;
                        state_next  = ST_IDLE;
                    end else begin
                        state_next = ST_LIT;
                    end
                end
            end
            ST_LIT: begin
                if (out_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_nz_reg ? rd_byte_reg : 8'h00;
                    m_last_next  = 1'b0;
                    m_eos_next   = 1'b0;
                    if (idx_last) begin
                        m_last_next = last_run_reg;
                        m_eos_next  = eos_reg;
                        done.valid  = 1'b1;
                        done.bank   = bank_reg;
                        state_next  = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        val_reg      <= val_next;
        lc_reg       <= lc_next;
        bank_reg     <= bank_next;
        last_run_reg <= last_run_next;
        eos_reg      <= eos_next;
        idx_reg      <= idx_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        m_eos_reg    <= m_eos_next;
    end

    // A new block clears its bank's nonzero marks; zero literals are never
    // written, they read back through a clear mark.
    assign nz_wr = (wr.clr ? '0 : nz_reg[wr.bank])
                   | (wr.we ? (LIT_MAX'(1) << wr.idx) : '0);

    // Read ahead at the next index so the byte is ready when it is sent.
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            lit_mem[wr.bank][wr.idx] <= wr.data;
        end
        if (wr.we || wr.clr) begin
            nz_reg[wr.bank] <= nz_wr;
        end
        rd_byte_reg <= lit_mem[bank_next][idx_next];
        rd_nz_reg   <= nz_reg[bank_next][idx_next];
    end

endmodule

`default_nettype wire

@@ hdl/zero_run_packer.sv @@
// Top level of the zero-run packer: front, command queue and back.
// Depends on zrp_pkg, zrp_front, zrp_queue and zrp_back.
//
//  Channel  Direction  Signals                          Carries
//  s_       in         s_tvalid s_tready s_tdata s_tlast  raw body bytes
//  m_       out        m_tvalid m_tready m_tdata m_tlast  packed bytes
//                      m_tuser
//  cfg_     in         cfg_we cfg_wdata                  zero run threshold
//
// Packed bytes leave at one per cycle while the receiver keeps m_tready
// high, with a stop in the idle state per pair to fetch the next command
// from the queue; an item causes up to two pairs.
// s_tready drops while a second pair waits to enter the queue, while the
// queue is full, or while the back still reads the literal bank the front
// needs next.
// aresetn is synchronous and active low; it clears the control state and
// sets the zero run threshold to 4. The literal store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module zero_run_packer (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // input item: [7:0] data_byte
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,
    // last_byte
    input  wire logic                      s_tlast,
    // result item: [7:0] packed_byte
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [7:0]                     m_tdata,
    // last_of_run
    output logic                           m_tlast,
    // [0] end_of_stream
    output logic                           m_tuser,
    input  wire logic                      cfg_we,
    input  wire logic [zrp_pkg::CFG_W-1:0] cfg_wdata
);
    import zrp_pkg::*;

    logic      q_push;
    zrp_cmd_t  q_push_cmd;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    zrp_cmd_t  q_head;
    zrp_wr_t   lit_wr;
    zrp_done_t lit_done;

    // Classify bytes, keep block state, write literals, issue pairs.
    zrp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd),
        .wr        (lit_wr),
        .done      (lit_done)
    );

    // Hold pair commands so the front runs ahead of the output.
    zrp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    // Emit varints and literal bytes; release a bank when it is read out.
    zrp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_head),
        .wr       (lit_wr),
        .done     (lit_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ hdl/zrp_checker.sv @@
// Port-level checks for the zero-run packer, bound to the top level.
// Depends only on the ports of zero_run_packer.
`timescale 1ns / 1ps
`default_nettype none

module zrp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    // A stalled output item holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // The end of the stream is always the last byte of its item's run.
    a_eos_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of stream without last of run");

    // Reset empties the output and frees the input side.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind zero_run_packer zrp_checker u_zrp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ bench/zero_run_packer_tb.sv @@
// Testbench for zero_run_packer: random and directed raw body streams, each
// packed result checked against an in-bench predictor of the packing rules.
// Depends on zrp_pkg and the zero_run_packer RTL.
`timescale 1ns / 1ps

module zero_run_packer_tb;
    import zrp_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 6;
    // Cycles with no item moving on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Idle cycles after the last result before a register write.
    localparam int CFG_SETTLE     = 8;
    // Idle cycles after the last result before the verdict.
    localparam int END_SETTLE     = 20;
    // Long receiver hold-off used to fill the block and stall its input.
    localparam int LONG_HOLD      = 200;
    localparam int RANDOM_ITEMS   = 12;

    // Varint byte layout: seven payload bits, top bit flags more bytes.
    localparam logic [7:0] VARINT_PAYLOAD = 8'h7f;
    localparam logic [7:0] VARINT_MORE    = 8'h80;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_of_run;
        logic       end_of_stream;
    } packed_out_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;      // [7:0] data_byte
    logic             s_tlast;      // last_byte
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;      // [7:0] packed_byte
    logic             m_tlast;      // last_of_run
    logic             m_tuser;      // [0] end_of_stream
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    zero_run_packer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------
    // Packing predictor: own copy of the register and of the packer state.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] run_thr_q      = RUN_THR_RST;
    logic             pk_in_block    = 1'b0;
    logic [ZC_W-1:0]  pk_lead_zeros  = '0;
    logic [7:0]       pk_lit[LIT_MAX];
    int               pk_lit_count   = 0;
    int               pk_tail_zeros  = 0;

    logic [7:0]       step_bytes[$];      // bytes caused by the current item
    packed_out_t      expected_bytes[$];  // packed bytes still to arrive
    int               failures = 0;

    function automatic void clear_packer_state();
        pk_in_block   = 1'b0;
        pk_lead_zeros = '0;
        pk_lit_count  = 0;
        pk_tail_zeros = 0;
    endfunction

    // Low seven-bit group first; flag every byte but the final one.
    function automatic void emit_varint(logic [ZC_W-1:0] v);
        logic [ZC_W-1:0] rest;
        rest = v;
        do begin
            if ((rest >> VARINT_BITS) == 0)
                step_bytes.push_back(rest[7:0] & VARINT_PAYLOAD);
            else
                step_bytes.push_back((rest[7:0] & VARINT_PAYLOAD) | VARINT_MORE);
            rest = rest >> VARINT_BITS;
        end while (rest != 0);
    endfunction

    function automatic void emit_block();
        emit_varint(pk_lead_zeros);
        emit_varint(ZC_W'(pk_lit_count));
        for (int k = 0; k < pk_lit_count && k < LIT_MAX; k++)
            step_bytes.push_back(pk_lit[k]);
    endfunction

    // Fold pending zeros into the open block, then optionally the new byte.
    function automatic void append_pending(logic [7:0] b, logic with_byte);
        while (pk_tail_zeros > 0 && pk_lit_count < LIT_MAX) begin
            pk_lit[pk_lit_count] = 8'h00;
            pk_lit_count++;
            pk_tail_zeros--;
        end
        pk_tail_zeros = 0;
        if (with_byte && pk_lit_count < LIT_MAX) begin
            pk_lit[pk_lit_count] = b;
            pk_lit_count++;
        end
    endfunction

    function automatic void predict_item(logic [7:0] b, logic lst);
        int          thr;
        packed_out_t res;
        thr = (run_thr_q == 0) ? 1 : int'(run_thr_q);
        step_bytes.delete();

        if (!pk_in_block) begin
            if (b == 8'h00) begin
                pk_lead_zeros++;
                // Saturated zero count leaves as a pair of its own.
                if (pk_lead_zeros == ZC_MAX) begin
                    emit_varint(pk_lead_zeros);
                    emit_varint('0);
                    pk_lead_zeros = '0;
                end
            end else begin
                pk_in_block   = 1'b1;
                pk_lit[0]     = b;
                pk_lit_count  = 1;
                pk_tail_zeros = 0;
            end
        end else if (b == 8'h00) begin
            pk_tail_zeros++;
            // Run reached the threshold: close the block, run becomes next count.
            if (pk_tail_zeros >= thr) begin
                emit_block();
                pk_in_block   = 1'b0;
                pk_lead_zeros = ZC_W'(pk_tail_zeros);
                pk_tail_zeros = 0;
                pk_lit_count  = 0;
            end
        end else if (pk_lit_count + pk_tail_zeros + 1 > LIT_MAX) begin
            // Store full: flush as is, pending zeros lead the next block.
            emit_block();
            pk_lead_zeros = ZC_W'(pk_tail_zeros);
            pk_tail_zeros = 0;
            pk_lit[0]     = b;
            pk_lit_count  = 1;
        end else begin
            append_pending(b, 1'b1);
        end

        if (lst) begin
            if (pk_in_block) begin
                if (pk_lit_count + pk_tail_zeros > LIT_MAX) begin
                    emit_block();
                    pk_lead_zeros = ZC_W'(pk_tail_zeros);
                end else begin
                    append_pending(8'h00, 1'b0);
                    emit_block();
                    pk_lead_zeros = '0;
                end
            end
            if (pk_lead_zeros != 0) begin
                emit_varint(pk_lead_zeros);
                emit_varint('0);
            end
            clear_packer_state();
        end

        foreach (step_bytes[i]) begin
            res.packed_byte   = step_bytes[i];
            res.last_of_run   = (i == step_bytes.size() - 1);
            res.end_of_stream = lst && (i == step_bytes.size() - 1);
            expected_bytes.push_back(res);
        end
    endfunction

    function automatic void check_result();
        packed_out_t want;
        if (expected_bytes.size() == 0) begin
            $error("unexpected packed byte %02h", m_tdata);
            failures++;
        end else begin
            want = expected_bytes.pop_front();
            if (m_tdata !== want.packed_byte) begin
                $error("packed_byte: expected %02h, got %02h", want.packed_byte, m_tdata);
                failures++;
            end
            if (m_tlast !== want.last_of_run) begin
                $error("last_of_run: expected %0b, got %0b", want.last_of_run, m_tlast);
                failures++;
            end
            if (m_tuser !== want.end_of_stream) begin
                $error("end_of_stream: expected %0b, got %0b", want.end_of_stream, m_tuser);
                failures++;
            end
        end
    endfunction

    // Sample both channels at the rising edge: predict first, then check, so
    // ordering within the step never matters.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            predict_item(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready)
            check_result();
    end

    // Watchdog: count cycles in which no item moves on either side.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request.
    // ------------------------------------------------------------------
    int sink_hold  = 0;   // long hold-off, counted down here
    int sink_stall = 0;   // current short/long random stall
    bit sink_idle  = 1'b0;
    bit src_idle   = 1'b0;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    initial begin
        int g;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_tready = 1'b0;
                sink_hold--;
            end else if (sink_stall > 0) begin
                m_tready = 1'b0;
                sink_stall--;
            end else if (sink_idle) begin
                g = pick_gap();
                m_tready   = (g == 0);
                sink_stall = (g > 0) ? g - 1 : 0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side. All tasks start and end at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = lst;
        // Hold the item until the block takes it.
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Send one body; its final byte carries the last flag.
    task automatic send_body(input byte_q_t body);
        foreach (body[i])
            send_byte(body[i], i == body.size() - 1);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_bytes.size() != 0) @(negedge aclk);
    endtask

    // Write the register only once the block has gone quiet.
    task automatic set_run_thr(input logic [CFG_W-1:0] v);
        wait_drained();
        repeat (CFG_SETTLE) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
        run_thr_q = v;
    endtask

    function automatic logic [7:0] random_nonzero();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 8'hff;
            1: return 8'h80;
            2: return 8'h01;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return {CFG_W{1'b1}};
        else
            return CFG_W'($urandom_range(1, 16));
    endfunction

    // Random body built from literal bursts, short and long zero runs, noise.
    task automatic send_random_stream(output int n_sent);
        byte_q_t body;
        int      thr;
        int      kind;
        int      len;
        thr  = (run_thr_q == 0) ? 1 : int'(run_thr_q);
        repeat ($urandom_range(1, 6)) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                len = $urandom_range(1, 10);
                repeat (len) body.push_back(random_nonzero());
            end else if (kind < 65) begin
                // Run that stays inside the block.
                len = (thr > 1) ? $urandom_range(1, thr - 1) : 1;
                repeat (len) body.push_back(8'h00);
            end else if (kind < 85) begin
                // Run that closes the block.
                len = $urandom_range(thr, thr + 4);
                repeat (len) body.push_back(8'h00);
            end else begin
                len = $urandom_range(1, 8);
                repeat (len)
                    body.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
            end
        end
        send_body(body);
        n_sent = body.size();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // Default threshold of four after reset.
        send_body('{8'h01});
        send_body('{8'h00});
        // Short run kept, run at threshold closes, trailing zero joins block.
        send_body('{8'hff, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h7f, 8'h00});
        // Leading zeros, then pending zeros below threshold at end of body.
        send_body('{8'h00, 8'h00, 8'h2a, 8'h00, 8'h00, 8'h00});
        // Threshold of zero behaves as one.
        set_run_thr('0);
        send_body('{8'h11, 8'h00, 8'h22, 8'h00, 8'h00});
        // Largest threshold the register holds.
        set_run_thr({CFG_W{1'b1}});
        send_body('{8'h33, 8'h00, 8'h00, 8'h44});
    endtask

    task automatic test_full_store();
        byte_q_t body;
        set_run_thr(CFG_W'(16));
        // Pending zeros plus a new byte overflow: they lead the next block.
        repeat (LIT_MAX - 2) body.push_back(random_nonzero());
        body.push_back(8'h00);
        body.push_back(8'h00);
        body.push_back(8'h5a);
        repeat (3) body.push_back(8'h00);
        send_body(body);
        // Trailing zeros that no longer fit at end of body: separate pair.
        body.delete();
        repeat (LIT_MAX - 2) body.push_back(random_nonzero());
        repeat (3) body.push_back(8'h00);
        send_body(body);
    endtask

    task automatic test_backpressure();
        byte_q_t body;
        set_run_thr(CFG_W'(1));
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        // Hold the receiver off while the sender streams short blocks
        // without gaps; both literal banks fill and the input stalls.
        sink_hold = LONG_HOLD;
        repeat (8) begin
            body.push_back(random_nonzero());
            body.push_back(8'h00);
        end
        send_body(body);
        // Pause the sender until every packed byte has come out.
        wait_drained();
        body.delete();
        repeat (8) body.push_back($urandom_range(0, 1) ? 8'h00 : random_nonzero());
        send_body(body);
    endtask

    task automatic test_random();
        int sent;
        int total;
        total = 0;
        while (total < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                set_run_thr(pick_threshold());
            // Some streams run with no idling at all on either side.
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            send_random_stream(sent);
            total += sent;
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        clear_packer_state();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_full_store();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (END_SETTLE) @(negedge aclk);
        if (failures == 0 && expected_bytes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/zrp_pkg.sv
hdl/zrp_front.sv
hdl/zrp_queue.sv
hdl/zrp_back.sv
hdl/zero_run_packer.sv
hdl/zrp_checker.sv
bench/zero_run_packer_tb.sv
